// ===== rtl/ppas_pkg.sv =====
// Package for the phased periodic action scheduler: modes, result status codes,
// sequencer states and the slot table entry type. No dependencies.
`timescale 1ns / 1ps

package ppas_pkg;

  // input item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // most fired actions reported for one tick
  localparam int          RES_CW      = 5;
  localparam logic [4:0]  MAX_RESULTS = 5'd16;

  // result status codes
  typedef enum logic [2:0] {
    ST_FIRED    = 3'd0,
    ST_NONE     = 3'd1,
    ST_ADDED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_TREAD,
    S_TCHK,
    S_TDIV,
    S_TNEXT,
    S_TEND,
    S_RREAD,
    S_RCHK,
    S_RDONE,
    S_EMIT
  } state_t;

  // one slot of the action table
  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] phase;
    logic [15:0] id;
  } slot_t;

endpackage

// ===== rtl/ppas_table.sv =====
// Slot table of the scheduler: one write port and one registered read port.
// Depends on ppas_pkg for the slot entry type.
`timescale 1ns / 1ps

module ppas_table #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IW-1:0]      wr_addr,
  input  ppas_pkg::slot_t    wr_data,
  input  logic [IW-1:0]      rd_addr,
  output ppas_pkg::slot_t    rd_data
);

  ppas_pkg::slot_t mem [SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ppas_mod.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor, one
// dividend bit per cycle. No package dependency.
`timescale 1ns / 1ps

module ppas_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);

  logic        busy;
  logic [4:0]  count;
  logic [31:0] dvd;
  logic [15:0] dsr;
  logic [16:0] trial;
  logic [16:0] diff;

  // one restoring step
  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        dvd   <= dividend;
        dsr   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        rem   <= (trial >= {1'b0, dsr}) ? diff[15:0] : trial[15:0];
        dvd   <= {dvd[30:0], 1'b0};
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/phased_periodic_action_scheduler.sv =====
// Phased periodic action scheduler: sequencer, slot table and shared
// remainder unit. Depends on ppas_pkg, ppas_table and ppas_mod.
//
// Usage: items enter on item_valid/item_ready, results leave on
// result_valid/result_ready; each transfer happens when valid and ready
// are both high. The block takes one item at a time: item_ready is high
// only while the sequencer is idle.
// An add gives one result; a remove reads and then checks each used slot
// in turn and compacts the table in place. A tick reads each used slot in
// turn; a slot whose frequency is nonzero and not above the tick also
// takes one pass through the serial remainder unit. Fired ids are reported
// in table order, the last flagged with last; a tick that fires nothing gives
// one result with status none fired. Results sit in an output register;
// while the receiver stalls the sequencer waits at that register and loses
// nothing. Mode 3 is taken and ignored. Reset empties the table, clears the
// id and tick counters and drops any pending result; it needs no clearing
// pass.
`timescale 1ns / 1ps

module phased_periodic_action_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] frequency,
  input  logic [15:0] phase,
  input  logic [15:0] action_id,
  input  logic [31:0] available_time,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [15:0] result_id,
  output logic [31:0] budget,
  output logic        last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  ppas_pkg::state_t  state, state_next;
  ppas_pkg::slot_t   rd_data;
  ppas_pkg::slot_t   tbl_wdata;
  ppas_pkg::status_t res_status;

  logic                       tbl_we;
  logic [IW-1:0]              tbl_waddr;
  logic [IW-1:0]              idx;
  logic [CW-1:0]              used;
  logic [CW-1:0]              keep;
  logic [15:0]                next_id;
  logic [31:0]                tick;
  logic [15:0]                aid_q;
  logic [31:0]                avail_q;
  logic [ppas_pkg::RES_CW-1:0] cnt;
  logic                       pend_v;
  logic [15:0]                pend_id;
  logic [15:0]                res_id;
  logic [31:0]                res_budget;
  logic                       res_last;
  logic                       emit_back;
  logic                       out_load;
  logic                       div_start;
  logic                       div_done;
  logic [15:0]                div_rem;
  logic                       last_idx;
  logic                       full;
  logic                       fire;

  assign item_ready = (state == ppas_pkg::S_IDLE);
  assign last_idx   = ((CW'(idx) + CW'(1)) == used);
  assign full       = (used == CW'(SLOTS));
  assign fire       = div_done && (div_rem == 16'd0) && (cnt != ppas_pkg::MAX_RESULTS);

  // slot table
  ppas_table #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // shared remainder unit
  ppas_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tick + {16'd0, rd_data.phase}),
    .divisor  (rd_data.freq),
    .done     (div_done),
    .rem      (div_rem)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppas_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    tbl_we     = 1'b0;
    tbl_waddr  = used[IW-1:0];
    tbl_wdata  = '{freq: frequency, phase: phase, id: next_id};
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ppas_pkg::S_IDLE: begin
        if (item_valid) begin
          case (mode)
            ppas_pkg::MODE_TICK: begin
              state_next = (used == '0) ? ppas_pkg::S_TEND : ppas_pkg::S_TREAD;
            end
            ppas_pkg::MODE_ADD: begin
              tbl_we     = !full;
              state_next = ppas_pkg::S_EMIT;
            end
            ppas_pkg::MODE_REMOVE: begin
              state_next = (used == '0) ? ppas_pkg::S_RDONE : ppas_pkg::S_RREAD;
            end
            default: ;
          endcase
        end
      end
      ppas_pkg::S_TREAD: state_next = ppas_pkg::S_TCHK;
      ppas_pkg::S_TCHK: begin
        if (rd_data.freq == 16'd0 || tick < {16'd0, rd_data.freq}) begin
          state_next = ppas_pkg::S_TNEXT;
        end else begin
          div_start  = 1'b1;
          state_next = ppas_pkg::S_TDIV;
        end
      end
      ppas_pkg::S_TDIV: begin
        if (div_done) begin
          state_next = (fire && pend_v) ? ppas_pkg::S_EMIT : ppas_pkg::S_TNEXT;
        end
      end
      ppas_pkg::S_TNEXT: begin
        state_next = last_idx ? ppas_pkg::S_TEND : ppas_pkg::S_TREAD;
      end
      ppas_pkg::S_TEND:  state_next = ppas_pkg::S_EMIT;
      ppas_pkg::S_RREAD: state_next = ppas_pkg::S_RCHK;
      ppas_pkg::S_RCHK: begin
        // kept entries slide down to the compacted position
        if (rd_data.id != aid_q) begin
          tbl_we    = 1'b1;
          tbl_waddr = keep[IW-1:0];
          tbl_wdata = rd_data;
        end
        state_next = last_idx ? ppas_pkg::S_RDONE : ppas_pkg::S_RREAD;
      end
      ppas_pkg::S_RDONE: state_next = ppas_pkg::S_EMIT;
      ppas_pkg::S_EMIT: begin
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = emit_back ? ppas_pkg::S_TNEXT : ppas_pkg::S_IDLE;
        end
      end
      default: state_next = ppas_pkg::S_IDLE;
    endcase
  end

  // datapath and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      next_id      <= '0;
      tick         <= '0;
      result_valid <= 1'b0;
      pend_v       <= 1'b0;
    end else begin
      // output register
      if (out_load) begin
        result_valid <= 1'b1;
        status       <= res_status;
        result_id    <= res_id;
        budget       <= res_budget;
        last         <= res_last;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        ppas_pkg::S_IDLE: begin
          if (item_valid) begin
            aid_q   <= action_id;
            avail_q <= available_time;
            idx     <= '0;
            keep    <= '0;
            cnt     <= '0;
            pend_v  <= 1'b0;
            case (mode)
              ppas_pkg::MODE_TICK: tick <= tick + 32'd1;
              ppas_pkg::MODE_ADD: begin
                emit_back  <= 1'b0;
                res_last   <= 1'b1;
                res_budget <= '0;
                if (!full) begin
                  used       <= used + CW'(1);
                  next_id    <= next_id + 16'd1;
                  res_status <= ppas_pkg::ST_ADDED;
                  res_id     <= next_id;
                end else begin
                  res_status <= ppas_pkg::ST_FULL;
                  res_id     <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ppas_pkg::S_TDIV: begin
          // a firing is held back until we know whether it is the last
          if (fire) begin
            if (pend_v) begin
              res_status <= ppas_pkg::ST_FIRED;
              res_id     <= pend_id;
              res_budget <= avail_q;
              res_last   <= 1'b0;
              emit_back  <= 1'b1;
            end
            pend_v  <= 1'b1;
            pend_id <= rd_data.id;
            cnt     <= cnt + ppas_pkg::RES_CW'(1);
          end
        end
        ppas_pkg::S_TNEXT: begin
          if (!last_idx) begin
            idx <= idx + IW'(1);
          end
        end
        ppas_pkg::S_TEND: begin
          res_status <= pend_v ? ppas_pkg::ST_FIRED : ppas_pkg::ST_NONE;
          res_id     <= pend_v ? pend_id : 16'd0;
          res_budget <= avail_q;
          res_last   <= 1'b1;
          emit_back  <= 1'b0;
        end
        ppas_pkg::S_RCHK: begin
          if (rd_data.id != aid_q) begin
            keep <= keep + CW'(1);
          end
          if (!last_idx) begin
            idx <= idx + IW'(1);
          end
        end
        ppas_pkg::S_RDONE: begin
          res_status <= (keep != used) ? ppas_pkg::ST_REMOVED : ppas_pkg::ST_NOTFOUND;
          res_id     <= aid_q;
          res_budget <= '0;
          res_last   <= 1'b1;
          emit_back  <= 1'b0;
          used       <= keep;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/sv/ppas_result_checker.sv =====
// Result checker for the phased periodic action scheduler: mirrors the action
// table, predicts the results of every item transfer and compares them in order.
// Depends on ppas_pkg.
`timescale 1ns / 1ps

module ppas_result_checker #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] frequency,
  input  logic [15:0] phase,
  input  logic [15:0] action_id,
  input  logic [31:0] available_time,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [2:0]  status,
  input  logic [15:0] result_id,
  input  logic [31:0] budget,
  input  logic        last,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    ppas_pkg::status_t status;
    logic [15:0]       id;
    logic [31:0]       budget;
    logic              last;
  } action_result_t;

  // results still owed by the block, oldest first
  action_result_t due_results[$];

  // mirror of the action table and counters
  logic [15:0] tab_freq  [SLOTS];
  logic [15:0] tab_phase [SLOTS];
  logic [15:0] tab_id    [SLOTS];
  int          tab_used = 0;
  logic [15:0] id_next = '0;
  logic [31:0] tick_now = '0;
  int          miss_count = 0;

  // apply one item to the mirror and queue the results it should cause
  task automatic schedule_item(input logic [1:0] m, input logic [15:0] f, p, aid,
                               input logic [31:0] avail);
    action_result_t batch[$];
    action_result_t r;
    logic [31:0] period;
    logic [31:0] sum;
    int keep;
    int i;
    r = '0;
    case (m)
      ppas_pkg::MODE_TICK: begin
        tick_now = tick_now + 32'd1;
        for (i = 0; i < tab_used; i++) begin
          period = {16'd0, tab_freq[i]};
          sum = tick_now + {16'd0, tab_phase[i]};
          // zero period never fires; sum wraps at 32 bits
          if (period != 0 && tick_now >= period && sum % period == 0 &&
              batch.size() < ppas_pkg::MAX_RESULTS) begin
            r.status = ppas_pkg::ST_FIRED;
            r.id = tab_id[i];
            r.budget = avail;
            batch = {batch, r};
          end
        end
        if (batch.size() == 0) begin
          r.status = ppas_pkg::ST_NONE;
          r.id = 16'd0;
          r.budget = avail;
          batch = {batch, r};
        end
      end
      ppas_pkg::MODE_ADD: begin
        if (tab_used >= SLOTS) begin
          r.status = ppas_pkg::ST_FULL;
          r.id = 16'd0;
        end else begin
          tab_freq[tab_used] = f;
          tab_phase[tab_used] = p;
          tab_id[tab_used] = id_next;
          tab_used++;
          r.status = ppas_pkg::ST_ADDED;
          r.id = id_next;
          id_next = id_next + 16'd1;
        end
        batch = {batch, r};
      end
      ppas_pkg::MODE_REMOVE: begin
        // drop every entry with this id and close the gaps in order
        keep = 0;
        for (i = 0; i < tab_used; i++) begin
          if (tab_id[i] != aid) begin
            tab_freq[keep] = tab_freq[i];
            tab_phase[keep] = tab_phase[i];
            tab_id[keep] = tab_id[i];
            keep++;
          end
        end
        r.status = (keep != tab_used) ? ppas_pkg::ST_REMOVED : ppas_pkg::ST_NOTFOUND;
        r.id = aid;
        tab_used = keep;
        batch = {batch, r};
      end
      default: begin
      end
    endcase
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    due_results = {due_results, batch};
  endtask

  // compare result transfers, then predict from item transfers
  always @(posedge clk) begin : watch
    action_result_t want;
    if (rst) begin
      tab_used = 0;
      id_next = '0;
      tick_now = '0;
      due_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("%t: unexpected result: status %0d id %0d budget %h last %0d",
                     $realtime, status, result_id, budget, last);
        end else begin
          want = due_results.pop_front();
          if (status !== want.status || result_id !== want.id ||
              budget !== want.budget || last !== want.last) begin
            miss_count++;
            if (miss_count <= 10) begin
              $display("%t: result mismatch: expected status %0d id %0d budget %h last %0d",
                       $realtime, want.status, want.id, want.budget, want.last);
              $display("%t:   got status %0d id %0d budget %h last %0d",
                       $realtime, status, result_id, budget, last);
            end
          end
        end
      end
      if (item_valid && item_ready)
        schedule_item(mode, frequency, phase, action_id, available_time);
    end
    errors <= miss_count;
    pending <= due_results.size();
  end

endmodule

// ===== tb/sv/tb_phased_periodic_action_scheduler.sv =====
// Testbench top for the phased periodic action scheduler: clock, reset, item
// and result traffic and the verdict. Depends on ppas_pkg, the scheduler RTL
// and ppas_result_checker.
`timescale 1ns / 1ps

module tb_phased_periodic_action_scheduler;

  localparam int         SLOTS        = 16;
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int         RANDOM_ITEMS = 280;
  localparam int         LONG_HOLD    = 400;
  localparam int         DRAIN_CYCLES = 700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  mode = ppas_pkg::MODE_TICK;
  logic [15:0] frequency = '0;
  logic [15:0] phase = '0;
  logic [15:0] action_id = '0;
  logic [31:0] available_time = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] result_id;
  logic [31:0] budget;
  logic        last;
  int          errors;
  int          pending;

  logic        calm = 1'b0;      // no idling on either side
  logic        hold_req = 1'b0;  // ask the result side for one long hold
  logic        hold_done = 1'b0;
  logic        track_ids = 1'b0;
  int          rx_hold = 0;
  logic [15:0] live_ids[$];

  always #5 clk = ~clk;

  phased_periodic_action_scheduler #(.SLOTS(SLOTS)) DUT (.*);

  ppas_result_checker #(.SLOTS(SLOTS)) u_checker (.*);

  // result side: random stall after each transfer, one long hold on request
  always @(posedge clk) begin : result_side
    int gap;
    if (rst) begin
      result_ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) result_ready <= 1'b1;
    end else if (!result_ready) begin
      result_ready <= 1'b1;
    end else if (result_valid) begin
      gap = calm ? 0 : $urandom_range(0, 10);
      if (hold_req && !hold_done) begin
        gap = LONG_HOLD;
        hold_done <= 1'b1;
      end
      if (gap != 0) begin
        result_ready <= 1'b0;
        rx_hold <= gap;
      end
    end
  end

  // ids believed to be in the table, taken from add and remove results
  always @(posedge clk) begin : id_watch
    int k;
    if (track_ids && result_valid && result_ready) begin
      if (status == ppas_pkg::ST_ADDED) begin
        live_ids = {live_ids, result_id};
      end else if (status == ppas_pkg::ST_REMOVED) begin
        for (k = live_ids.size() - 1; k >= 0; k--)
          if (live_ids[k] == result_id) live_ids.delete(k);
      end
    end
  end

  // offer one item after a random gap and hold it until the transfer
  task automatic send_item(input logic [1:0] m, input logic [15:0] f, p, aid,
                           input logic [31:0] avail);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    frequency <= f;
    phase <= p;
    action_id <= aid;
    available_time <= avail;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic do_tick(input logic [31:0] avail);
    send_item(ppas_pkg::MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom), avail);
  endtask

  task automatic add_action(input logic [15:0] f, p);
    send_item(ppas_pkg::MODE_ADD, f, p, 16'($urandom), $urandom);
  endtask

  task automatic remove_action(input logic [15:0] aid);
    send_item(ppas_pkg::MODE_REMOVE, 16'($urandom), 16'($urandom), aid, $urandom);
  endtask

  initial begin : stimulus
    int n;
    int i;
    int sel;
    int pick;
    int guard;
    logic [15:0] f;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table: tick, remove of a missing id, unused mode
    do_tick(32'hFFFF_FFFF);
    remove_action(16'hFFFF);
    send_item(MODE_IGNORED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);

    // every tick, never, out of reach, even period, odd period with top phase
    add_action(16'd1, 16'd0);
    add_action(16'd0, 16'hFFFF);
    add_action(16'hFFFF, 16'hFFFF);
    add_action(16'd2, 16'd1);
    add_action(16'd3, 16'hFFFF);
    do_tick(32'd0);
    do_tick(32'hA5A5_A5A5);
    do_tick(32'h5A5A_5A5A);

    // fill the table, then one add too many
    for (i = 0; i < SLOTS - 4; i++)
      add_action(16'($urandom_range(1, 4)), 16'($urandom_range(0, 3)));
    do_tick($urandom);
    remove_action(16'd3);
    remove_action(16'd3);

    // remove everything but id 0
    for (i = 1; i < SLOTS; i++)
      if (i != 3) remove_action(16'(i));

    // last entry gone, then a tick on the empty table
    remove_action(16'd0);
    do_tick($urandom);

    // random traffic, mostly small periods so that ticks fire often
    track_ids <= 1'b1;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == RANDOM_ITEMS / 3) hold_req <= 1'b1;
      calm <= (n >= 200 && n < 240);
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        send_item(MODE_IGNORED, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else if (sel < 43) begin
        do_tick($urandom);
      end else if (sel < 78) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) f = 16'd0;
        else if (pick == 1) f = 16'($urandom);
        else if (pick == 2) f = 16'($urandom_range(41, 300));
        else if (pick < 16) f = 16'($urandom_range(1, 6));
        else f = 16'($urandom_range(7, 40));
        add_action(f, 16'($urandom));
      end else if (sel < 92 && live_ids.size() != 0) begin
        remove_action(live_ids[$urandom_range(0, live_ids.size() - 1)]);
      end else begin
        remove_action(16'($urandom));
      end
      if (sel >= 3) n++;
    end
    item_valid <= 1'b0;

    // drain, then allow for a last tick still being scanned
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 200000);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0)
      $display("** phased_periodic_action_scheduler: PASSED **");
    else
      $display("** phased_periodic_action_scheduler: FAILED **");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #100_000_000;
    $display("** phased_periodic_action_scheduler: FAILED **");
    $finish;
  end

endmodule
